### design/amgs_pkg.sv
// amgs_pkg: shared constants, field layout, microcode word type and microcode rom
// for the adjacency matrix graph store; used by the top level and its checker
`timescale 1ns / 1ps

package amgs_pkg;

    // built size of the store
    localparam int MAX_NODES   = 32;
    localparam int WEIGHT_BITS = 16;
    localparam int DEPTH       = MAX_NODES * MAX_NODES;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(MAX_NODES + 1);

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int NODE_W  = 5;
    localparam int VAL_W   = 16;
    localparam int DEG_W   = 6;
    localparam int TOTAL_W = 16;
    localparam int CFG_W   = 6;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // stream layout
    localparam int I_U_LSB   = 0;
    localparam int I_V_LSB   = I_U_LSB + NODE_W;
    localparam int I_W_LSB   = I_V_LSB + NODE_W;
    localparam int I_DATA_W  = ((I_W_LSB + VAL_W + 7) / 8) * 8;
    localparam int O_IDX_LSB = 0;
    localparam int O_VAL_LSB = O_IDX_LSB + NODE_W;
    localparam int O_DEG_LSB = O_VAL_LSB + VAL_W;
    localparam int O_TOT_LSB = O_DEG_LSB + DEG_W;
    localparam int O_DATA_W  = ((O_TOT_LSB + TOTAL_W + 7) / 8) * 8;
    localparam int O_USER_W  = 2;
    localparam int U_NONE    = 0;
    localparam int U_ERR     = 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_WQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_NL  = 2'd2;
    localparam logic [OP_W-1:0] OP_DEG = 2'd3;

    // memory address sources
    localparam logic [1:0] A_CLR = 2'd0;
    localparam logic [1:0] A_UV  = 2'd1;
    localparam logic [1:0] A_VU  = 2'd2;
    localparam logic [1:0] A_COL = 2'd3;

    // result kinds
    localparam logic [2:0] E_NONE  = 3'd0;
    localparam logic [2:0] E_ACK   = 3'd1;
    localparam logic [2:0] E_RD    = 3'd2;
    localparam logic [2:0] E_DEG   = 3'd3;
    localparam logic [2:0] E_PEND  = 3'd4;
    localparam logic [2:0] E_PLAST = 3'd5;
    localparam logic [2:0] E_ERR   = 3'd6;

    // jump conditions
    localparam logic [3:0] J_NEVER     = 4'd0;
    localparam logic [3:0] J_ALWAYS    = 4'd1;
    localparam logic [3:0] J_CLR_BUSY  = 4'd2;
    localparam logic [3:0] J_NO_ACCEPT = 4'd3;
    localparam logic [3:0] J_ERR       = 4'd4;
    localparam logic [3:0] J_OP_ADD    = 4'd5;
    localparam logic [3:0] J_OP_WQ     = 4'd6;
    localparam logic [3:0] J_OP_NL     = 4'd7;
    localparam logic [3:0] J_COL_ZERO  = 4'd8;
    localparam logic [3:0] J_NOT_POS   = 4'd9;

    // program steps
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] S_CLR  = 5'd0;
    localparam logic [PC_W-1:0] S_IDLE = 5'd1;
    localparam logic [PC_W-1:0] S_DISP = 5'd2;
    localparam logic [PC_W-1:0] S_OP1  = 5'd3;
    localparam logic [PC_W-1:0] S_OP2  = 5'd4;
    localparam logic [PC_W-1:0] S_OP3  = 5'd5;
    localparam logic [PC_W-1:0] S_DG0  = 5'd6;
    localparam logic [PC_W-1:0] S_DG1  = 5'd7;
    localparam logic [PC_W-1:0] S_DG2  = 5'd8;
    localparam logic [PC_W-1:0] S_DGE  = 5'd9;
    localparam logic [PC_W-1:0] S_AD0  = 5'd10;
    localparam logic [PC_W-1:0] S_AD1  = 5'd11;
    localparam logic [PC_W-1:0] S_AD2  = 5'd12;
    localparam logic [PC_W-1:0] S_WQ0  = 5'd13;
    localparam logic [PC_W-1:0] S_WQ1  = 5'd14;
    localparam logic [PC_W-1:0] S_NL0  = 5'd15;
    localparam logic [PC_W-1:0] S_NL1  = 5'd16;
    localparam logic [PC_W-1:0] S_NL2  = 5'd17;
    localparam logic [PC_W-1:0] S_NL3  = 5'd18;
    localparam logic [PC_W-1:0] S_NLE  = 5'd19;
    localparam logic [PC_W-1:0] S_ERR  = 5'd20;

    typedef struct packed {
        logic            mem_we;
        logic            mem_re;
        logic [1:0]      addr_sel;
        logic            clr_inc;
        logic            ready;
        logic            edge_inc;
        logic            init_scan;
        logic            col_dec;
        logic            cnt_inc;
        logic            pend_load;
        logic [2:0]      emit;
        logic [3:0]      cond;
        logic [PC_W-1:0] target;
    } ctl_t;

    function automatic ctl_t ucode(logic [PC_W-1:0] pc);
        ctl_t c;
        c = '0;
        c.cond = J_NEVER;
        c.emit = E_NONE;
        case (pc)
            S_CLR: begin
                c.mem_we = 1'b1; c.addr_sel = A_CLR; c.clr_inc = 1'b1;
                c.cond = J_CLR_BUSY; c.target = S_CLR;
            end
            S_IDLE: begin
                c.ready = 1'b1; c.cond = J_NO_ACCEPT; c.target = S_IDLE;
            end
            S_DISP: begin c.cond = J_ERR;    c.target = S_ERR; end
            S_OP1:  begin c.cond = J_OP_ADD; c.target = S_AD0; end
            S_OP2:  begin c.cond = J_OP_WQ;  c.target = S_WQ0; end
            S_OP3:  begin c.cond = J_OP_NL;  c.target = S_NL0; end
            S_DG0:  begin c.init_scan = 1'b1; end
            S_DG1: begin
                c.mem_re = 1'b1; c.addr_sel = A_COL; c.col_dec = 1'b1;
                c.cond = J_COL_ZERO; c.target = S_DGE;
            end
            S_DG2: begin c.cnt_inc = 1'b1; c.cond = J_ALWAYS; c.target = S_DG1; end
            S_DGE: begin c.emit = E_DEG; c.cond = J_ALWAYS; c.target = S_IDLE; end
            S_AD0: begin c.mem_we = 1'b1; c.addr_sel = A_UV; end
            S_AD1: begin c.mem_we = 1'b1; c.addr_sel = A_VU; c.edge_inc = 1'b1; end
            S_AD2: begin c.emit = E_ACK; c.cond = J_ALWAYS; c.target = S_IDLE; end
            S_WQ0: begin c.mem_re = 1'b1; c.addr_sel = A_UV; end
            S_WQ1: begin c.emit = E_RD; c.cond = J_ALWAYS; c.target = S_IDLE; end
            S_NL0: begin c.init_scan = 1'b1; end
            S_NL1: begin
                c.mem_re = 1'b1; c.addr_sel = A_COL; c.col_dec = 1'b1;
                c.cond = J_COL_ZERO; c.target = S_NLE;
            end
            S_NL2: begin c.cond = J_NOT_POS; c.target = S_NL1; end
            S_NL3: begin
                c.emit = E_PEND; c.pend_load = 1'b1;
                c.cond = J_ALWAYS; c.target = S_NL1;
            end
            S_NLE: begin c.emit = E_PLAST; c.cond = J_ALWAYS; c.target = S_IDLE; end
            S_ERR: begin c.emit = E_ERR; c.cond = J_ALWAYS; c.target = S_IDLE; end
            default: begin c.cond = J_ALWAYS; c.target = S_IDLE; end
        endcase
        return c;
    endfunction

    // input weight to stored width: sign-extend, then keep WEIGHT_BITS
    function automatic logic [WEIGHT_BITS-1:0] to_store(logic [VAL_W-1:0] w);
        logic signed [31:0] t;
        t = 32'($signed(w));
        return t[WEIGHT_BITS-1:0];
    endfunction

    // stored weight back to the result field width
    function automatic logic [VAL_W-1:0] to_field(logic [WEIGHT_BITS-1:0] x);
        logic signed [31:0] t;
        t = 32'($signed(x));
        return t[VAL_W-1:0];
    endfunction

endpackage

### design/adjacency_matrix_graph_store.sv
// adjacency_matrix_graph_store: symmetric weighted adjacency matrix with a
// microcoded sequencer over one single-port weight memory; depends on amgs_pkg
`timescale 1ns / 1ps

// channel  | ports                                     | item
// ---------+-------------------------------------------+---------------------------------------
// input    | s_tvalid s_tready s_tdata s_tuser         | operation, node_u, node_v, edge_weight
// result   | m_tvalid m_tready m_tdata m_tuser m_tlast | node_index .. edge_total, flags, last
// config   | cfg_wr_en cfg_wr_data                     | node_count
//
// one item at a time, s_tready high only in the idle step: add edge writes both
// mirrored entries and weight query reads one through the one-entry-per-cycle memory
// port, an index error goes to its error result, degree runs the two-step row scan loop and
// neighbor list the NL1, NL2, NL3 loop over active nodes; after reset a clearing pass
// writes zero to all MAX_NODES*MAX_NODES entries, one per cycle; no item is taken meanwhile
// a stalled result register holds the program at its emit step for the stall cycles

module adjacency_matrix_graph_store (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [amgs_pkg::CFG_W-1:0]         cfg_wr_data,   // node_count
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [amgs_pkg::I_DATA_W-1:0]      s_tdata,       // node_u, node_v, edge_weight
    input  logic [amgs_pkg::OP_W-1:0]          s_tuser,       // operation
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [amgs_pkg::O_DATA_W-1:0]      m_tdata,       // node_index, edge_value,
                                                              // neighbor_count, edge_total
    output logic [amgs_pkg::O_USER_W-1:0]      m_tuser,       // none_found, index_error
    output logic                               m_tlast        // is_last
);

    // sequencer
    logic [amgs_pkg::PC_W-1:0]        pc_reg, pc_next;
    amgs_pkg::ctl_t                   ctl;
    logic                             take;
    logic                             stall;
    logic                             emit_active;
    logic                             out_free;
    logic                             s_fire;

    // captured item
    logic [amgs_pkg::OP_W-1:0]        op_reg;
    logic [amgs_pkg::NODE_W-1:0]      u_reg;
    logic [amgs_pkg::NODE_W-1:0]      v_reg;
    logic [amgs_pkg::VAL_W-1:0]       w_reg;

    // datapath state
    logic [amgs_pkg::CFG_W-1:0]       node_count_reg;
    logic [amgs_pkg::TOTAL_W-1:0]     edge_cnt_reg;
    logic [amgs_pkg::ADDR_W-1:0]      clr_reg;
    logic [amgs_pkg::CNT_W-1:0]       col_reg;
    logic [amgs_pkg::CNT_W-1:0]       cnt_reg;
    logic                             pend_valid_reg;
    logic [amgs_pkg::NODE_W-1:0]      pend_idx_reg;
    logic [amgs_pkg::WEIGHT_BITS-1:0] pend_val_reg;

    // weight memory
    logic [amgs_pkg::WEIGHT_BITS-1:0] mem [amgs_pkg::DEPTH];
    logic [amgs_pkg::WEIGHT_BITS-1:0] rd_reg;
    logic [amgs_pkg::ADDR_W-1:0]      mem_addr;
    logic [amgs_pkg::WEIGHT_BITS-1:0] mem_wdata;
    logic                             rd_pos;

    // result register
    logic                             m_tvalid_reg;
    logic [amgs_pkg::NODE_W-1:0]      o_idx_reg, o_idx_next;
    logic [amgs_pkg::VAL_W-1:0]       o_val_reg, o_val_next;
    logic [amgs_pkg::DEG_W-1:0]       o_deg_reg, o_deg_next;
    logic [amgs_pkg::TOTAL_W-1:0]     o_tot_reg;
    logic                             o_last_reg, o_last_next;
    logic                             o_none_reg, o_none_next;
    logic                             o_err_reg, o_err_next;

    // range check
    logic [amgs_pkg::CNT_W-1:0]       n_eff;
    logic                             idx_err;

    assign ctl      = amgs_pkg::ucode(pc_reg);
    assign s_tready = ctl.ready;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // a pending neighbor is only sent once a later one shows it is not the last
    assign emit_active = (ctl.emit != amgs_pkg::E_NONE)
                      && ((ctl.emit != amgs_pkg::E_PEND) || pend_valid_reg);
    assign stall = emit_active && !out_free;

    always_comb begin
        if (32'(node_count_reg) > amgs_pkg::MAX_NODES) begin
            n_eff = amgs_pkg::CNT_W'(amgs_pkg::MAX_NODES);
        end else begin
            n_eff = amgs_pkg::CNT_W'(node_count_reg);
        end
    end

    // node_v only matters for add edge and weight query
    assign idx_err = (32'(u_reg) >= 32'(n_eff))
                  || (((op_reg == amgs_pkg::OP_ADD) || (op_reg == amgs_pkg::OP_WQ))
                      && (32'(v_reg) >= 32'(n_eff)));

    // stored weight > 0
    assign rd_pos = !rd_reg[amgs_pkg::WEIGHT_BITS-1] && (|rd_reg);

    // jump condition select
    always_comb begin
        case (ctl.cond)
            amgs_pkg::J_NEVER:     take = 1'b0;
            amgs_pkg::J_ALWAYS:    take = 1'b1;
            amgs_pkg::J_CLR_BUSY:  take = (clr_reg != amgs_pkg::ADDR_W'(amgs_pkg::DEPTH - 1));
            amgs_pkg::J_NO_ACCEPT: take = !s_fire;
            amgs_pkg::J_ERR:       take = idx_err;
            amgs_pkg::J_OP_ADD:    take = (op_reg == amgs_pkg::OP_ADD);
            amgs_pkg::J_OP_WQ:     take = (op_reg == amgs_pkg::OP_WQ);
            amgs_pkg::J_OP_NL:     take = (op_reg == amgs_pkg::OP_NL);
            amgs_pkg::J_COL_ZERO:  take = (col_reg == '0);
            amgs_pkg::J_NOT_POS:   take = !rd_pos;
            default:               take = 1'b0;
        endcase
    end

    always_comb begin
        if (stall) begin
            pc_next = pc_reg;
        end else if (take) begin
            pc_next = ctl.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    // memory address select; the scan reads column col-1 while col counts down
    always_comb begin
        case (ctl.addr_sel)
            amgs_pkg::A_CLR: mem_addr = clr_reg;
            amgs_pkg::A_UV:  mem_addr = amgs_pkg::ADDR_W'(32'(u_reg) * amgs_pkg::MAX_NODES
                                                          + 32'(v_reg));
            amgs_pkg::A_VU:  mem_addr = amgs_pkg::ADDR_W'(32'(v_reg) * amgs_pkg::MAX_NODES
                                                          + 32'(u_reg));
            amgs_pkg::A_COL: mem_addr = amgs_pkg::ADDR_W'(32'(u_reg) * amgs_pkg::MAX_NODES
                                                          + 32'(col_reg) - 1);
            default:         mem_addr = clr_reg;
        endcase
        if (ctl.addr_sel == amgs_pkg::A_CLR) begin
            mem_wdata = '0;
        end else begin
            mem_wdata = amgs_pkg::to_store(w_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mem_we && !stall) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (ctl.mem_re && !stall) begin
            rd_reg <= mem[mem_addr];
        end
    end

    // sequencer and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= amgs_pkg::S_CLR;
            clr_reg        <= '0;
            node_count_reg <= amgs_pkg::CFG_W'(32);
            edge_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            col_reg        <= '0;
            cnt_reg        <= '0;
        end else begin
            pc_reg <= pc_next;
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
            if (!stall) begin
                if (ctl.clr_inc) begin
                    clr_reg <= clr_reg + 1'b1;
                end
                // saturating add-edge counter
                if (ctl.edge_inc && (edge_cnt_reg != amgs_pkg::TOTAL_MAX)) begin
                    edge_cnt_reg <= edge_cnt_reg + 1'b1;
                end
                if (ctl.init_scan) begin
                    col_reg        <= n_eff;
                    cnt_reg        <= '0;
                    pend_valid_reg <= 1'b0;
                end else if (ctl.col_dec && (col_reg != '0)) begin
                    col_reg <= col_reg - 1'b1;
                end
                if (ctl.cnt_inc && rd_pos) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (ctl.pend_load) begin
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    // captured item and pending neighbor
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg <= s_tuser;
            u_reg  <= s_tdata[amgs_pkg::I_U_LSB +: amgs_pkg::NODE_W];
            v_reg  <= s_tdata[amgs_pkg::I_V_LSB +: amgs_pkg::NODE_W];
            w_reg  <= s_tdata[amgs_pkg::I_W_LSB +: amgs_pkg::VAL_W];
        end
        if (ctl.pend_load && !stall) begin
            // col_reg already points at the column just read
            pend_idx_reg <= amgs_pkg::NODE_W'(col_reg);
            pend_val_reg <= rd_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_active && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result fields by kind; only edge_total is common to all
    always_comb begin
        o_idx_next  = '0;
        o_val_next  = '0;
        o_deg_next  = '0;
        o_last_next = 1'b1;
        o_none_next = 1'b0;
        o_err_next  = 1'b0;
        case (ctl.emit)
            amgs_pkg::E_RD: begin
                o_val_next = amgs_pkg::to_field(rd_reg);
            end
            amgs_pkg::E_DEG: begin
                o_deg_next = amgs_pkg::DEG_W'(cnt_reg);
            end
            amgs_pkg::E_PEND: begin
                o_idx_next  = pend_idx_reg;
                o_val_next  = amgs_pkg::to_field(pend_val_reg);
                o_last_next = 1'b0;
            end
            amgs_pkg::E_PLAST: begin
                // last neighbor, or the empty-list marker
                if (pend_valid_reg) begin
                    o_idx_next = pend_idx_reg;
                    o_val_next = amgs_pkg::to_field(pend_val_reg);
                end else begin
                    o_none_next = 1'b1;
                end
            end
            amgs_pkg::E_ERR: begin
                o_err_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (emit_active && out_free) begin
            o_idx_reg  <= o_idx_next;
            o_val_reg  <= o_val_next;
            o_deg_reg  <= o_deg_next;
            o_tot_reg  <= edge_cnt_reg;
            o_last_reg <= o_last_next;
            o_none_reg <= o_none_next;
            o_err_reg  <= o_err_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {o_err_reg, o_none_reg};

    always_comb begin
        m_tdata = '0;
        m_tdata[amgs_pkg::O_IDX_LSB +: amgs_pkg::NODE_W]  = o_idx_reg;
        m_tdata[amgs_pkg::O_VAL_LSB +: amgs_pkg::VAL_W]   = o_val_reg;
        m_tdata[amgs_pkg::O_DEG_LSB +: amgs_pkg::DEG_W]   = o_deg_reg;
        m_tdata[amgs_pkg::O_TOT_LSB +: amgs_pkg::TOTAL_W] = o_tot_reg;
    end

endmodule

### design/amgs_checker.sv
// amgs_checker: port-level assertions for the adjacency matrix graph store,
// bound to the top level; depends on amgs_pkg
`timescale 1ns / 1ps

module amgs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [amgs_pkg::O_DATA_W-1:0] m_tdata,
    input logic [amgs_pkg::O_USER_W-1:0] m_tuser,
    input logic                          m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // reset starts the clearing pass with nothing taken or shown
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("ready or valid right after reset");

    // only neighbor entries are non-last, and they carry a positive weight
    a_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tuser == '0)
            && !m_tdata[amgs_pkg::O_VAL_LSB + amgs_pkg::VAL_W - 1]
            && (m_tdata[amgs_pkg::O_VAL_LSB +: amgs_pkg::VAL_W] != '0)
            && (m_tdata[amgs_pkg::O_DEG_LSB +: amgs_pkg::DEG_W] == '0))
        else $error("bad non-last result");

    // an index error is a single item with only edge_total set
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[amgs_pkg::U_ERR] |-> m_tlast && !m_tuser[amgs_pkg::U_NONE]
            && (m_tdata[amgs_pkg::O_TOT_LSB-1:0] == '0))
        else $error("bad index error result");

endmodule

bind adjacency_matrix_graph_store amgs_checker u_amgs_checker (.*);

### tb/tb_adjacency_matrix_graph_store.sv
`timescale 1ns / 1ps
// tb_adjacency_matrix_graph_store: self-checking bench for the adjacency matrix graph store
// runs a directed table, then random traffic checked against a shadow matrix
// depends on amgs_pkg and the adjacency_matrix_graph_store top level

module tb_adjacency_matrix_graph_store;
    import amgs_pkg::*;

    // table row kinds
    localparam bit ROW_ITEM = 1'b0;
    localparam bit ROW_CFG  = 1'b1;

    localparam int PLAN_LEN      = 26;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 35;
    localparam int TAIL_ITEMS    = 20;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 100;     // about one full row scan
    localparam int DRAIN_SPIN    = 200000;

    // one result item as the block should produce it
    typedef struct packed {
        logic [NODE_W-1:0]  node_index;
        logic [VAL_W-1:0]   edge_value;
        logic [DEG_W-1:0]   neighbor_count;
        logic [TOTAL_W-1:0] edge_total;
        logic               is_last;
        logic               none_found;
        logic               index_error;
    } reply_t;

    // one row of the directed table; typed rows carry their single result
    typedef struct packed {
        logic               is_cfg;
        logic [CFG_W-1:0]   cfg;
        logic [OP_W-1:0]    op;
        logic [NODE_W-1:0]  u;
        logic [NODE_W-1:0]  v;
        logic [VAL_W-1:0]   w;
        logic               typed;
        logic [VAL_W-1:0]   want_val;
        logic [DEG_W-1:0]   want_deg;
        logic [TOTAL_W-1:0] want_tot;
        logic               want_none;
        logic               want_err;
    } step_t;

    // kind, cfg, op, u, v, weight, typed, then value, degree, total, none found, index error
    localparam step_t PLAN [PLAN_LEN] = '{
        // fresh store: everything reads as zero, no neighbors anywhere
        '{ROW_ITEM, 6'd0,  OP_WQ,  5'd0,  5'd0,  16'h0000, 1'b1, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_DEG, 5'd31, 5'd0,  16'h0000, 1'b1, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_NL,  5'd5,  5'd0,  16'h0000, 1'b1, 16'h0000, 6'd0, 16'd0, 1'b1, 1'b0},
        // weight extremes, read back from the mirrored side
        '{ROW_ITEM, 6'd0,  OP_ADD, 5'd31, 5'd0,  16'h7fff, 1'b1, 16'h0000, 6'd0, 16'd1, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_ADD, 5'd0,  5'd1,  16'h8000, 1'b1, 16'h0000, 6'd0, 16'd2, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_WQ,  5'd0,  5'd31, 16'h0000, 1'b1, 16'h7fff, 6'd0, 16'd2, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_WQ,  5'd1,  5'd0,  16'h0000, 1'b1, 16'h8000, 6'd0, 16'd2, 1'b0, 1'b0},
        // self loop, then a small positive, a negative and a zero edge on node 7
        '{ROW_ITEM, 6'd0,  OP_ADD, 5'd7,  5'd7,  16'h0100, 1'b1, 16'h0000, 6'd0, 16'd3, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_ADD, 5'd7,  5'd31, 16'h0001, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_ADD, 5'd3,  5'd7,  16'hffff, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_ADD, 5'd7,  5'd0,  16'h0000, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_NL,  5'd7,  5'd31, 16'h0000, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_DEG, 5'd7,  5'd0,  16'h0000, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_NL,  5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_WQ,  5'd7,  5'd3,  16'h0000, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_ADD, 5'd0,  5'd31, 16'h5a5a, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        // shrink to 8 nodes: out-of-range u or v is an error, node 31 no longer scanned
        '{ROW_CFG,  6'd8,  OP_ADD, 5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_ADD, 5'd8,  5'd0,  16'h1234, 1'b1, 16'h0000, 6'd0, 16'd7, 1'b0, 1'b1},
        '{ROW_ITEM, 6'd0,  OP_WQ,  5'd0,  5'd8,  16'h0000, 1'b1, 16'h0000, 6'd0, 16'd7, 1'b0, 1'b1},
        '{ROW_ITEM, 6'd0,  OP_NL,  5'd7,  5'd0,  16'h0000, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_DEG, 5'd8,  5'd0,  16'h0000, 1'b1, 16'h0000, 6'd0, 16'd7, 1'b0, 1'b1},
        // v is ignored by a neighbor list, so an out-of-range v is no error
        '{ROW_ITEM, 6'd0,  OP_NL,  5'd3,  5'd31, 16'h0000, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        // zero nodes: every index fails
        '{ROW_CFG,  6'd0,  OP_ADD, 5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_DEG, 5'd0,  5'd0,  16'h0000, 1'b1, 16'h0000, 6'd0, 16'd7, 1'b0, 1'b1},
        // count above the built size acts as the built size
        '{ROW_CFG,  6'd63, OP_ADD, 5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_ITEM, 6'd0,  OP_DEG, 5'd31, 5'd0,  16'h0000, 1'b0, 16'h0000, 6'd0, 16'd0, 1'b0, 1'b0}
    };

    // node counts of the random phases: full, tiny, mid, single node, oversize
    localparam logic [CFG_W-1:0] PHASE_NODES [PHASES] = '{
        6'd32, 6'd3, 6'd32, 6'd17, 6'd1, 6'd63, 6'd9, 6'd32
    };
    // idle percentages per phase, cycled: none, sender idle, receiver stall, both light
    localparam int SEND_IDLE [4] = '{0, 79, 0, 12};
    localparam int RECV_IDLE [4] = '{0, 0, 79, 12};

    // dut ports; the inputs are known from time zero
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [I_DATA_W-1:0]  s_tdata     = '0;     // node_u, node_v, edge_weight
    logic [OP_W-1:0]      s_tuser     = OP_ADD; // operation
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [O_DATA_W-1:0]  m_tdata;              // node_index, edge_value, neighbor_count, edge_total
    logic [O_USER_W-1:0]  m_tuser;              // none_found, index_error
    logic                 m_tlast;              // is_last

    // shadow copy of the block state and the results still owed
    logic [VAL_W-1:0]     shadow_weight [MAX_NODES][MAX_NODES];
    logic [TOTAL_W-1:0]   shadow_edges;
    logic [CFG_W-1:0]     shadow_nodes;
    reply_t               graph_replies [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatch_count = 0;

    adjacency_matrix_graph_store uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // 2 ns clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // hard stop well past the slowest correct run (long stalled neighbor scans)
    initial begin
        #2_000_000;
        $display("adjacency_matrix_graph_store: mismatch");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // effective node count: anything above the built size acts as the built size
    function automatic int active_count();
        return (shadow_nodes > MAX_NODES) ? MAX_NODES : int'(shadow_nodes);
    endfunction

    // apply one operation to the shadow matrix and queue the results it owes
    function automatic void apply_graph_op(input logic [OP_W-1:0] op,
                                           input logic [NODE_W-1:0] u,
                                           input logic [NODE_W-1:0] v,
                                           input logic [VAL_W-1:0] w);
        int     n;
        int     deg;
        bit     uses_v;
        bit     have_prev;
        reply_t r;
        reply_t prev;
        n      = active_count();
        uses_v = (op == OP_ADD) || (op == OP_WQ);
        r      = '0;
        r.is_last = 1'b1;
        if (u >= n || (uses_v && v >= n)) begin
            // range error: nothing moves, only the running total is reported
            r.edge_total  = shadow_edges;
            r.index_error = 1'b1;
            graph_replies.push_back(r);
        end else begin
            case (op)
                OP_ADD: begin
                    shadow_weight[u][v] = w;
                    shadow_weight[v][u] = w;
                    if (shadow_edges != TOTAL_MAX) begin
                        shadow_edges++;
                    end
                    r.edge_total = shadow_edges;
                    graph_replies.push_back(r);
                end
                OP_WQ: begin
                    r.edge_total = shadow_edges;
                    r.edge_value = shadow_weight[u][v];
                    graph_replies.push_back(r);
                end
                OP_NL: begin
                    // highest column first, only strictly positive weights count
                    have_prev = 1'b0;
                    prev      = '0;
                    for (int i = n - 1; i >= 0; i--) begin
                        if ($signed(shadow_weight[u][i]) > 0) begin
                            if (have_prev) begin
                                graph_replies.push_back(prev);
                            end
                            prev            = '0;
                            prev.node_index = NODE_W'(i);
                            prev.edge_value = shadow_weight[u][i];
                            prev.edge_total = shadow_edges;
                            have_prev       = 1'b1;
                        end
                    end
                    if (have_prev) begin
                        prev.is_last = 1'b1;
                        graph_replies.push_back(prev);
                    end else begin
                        r.edge_total = shadow_edges;
                        r.none_found = 1'b1;
                        graph_replies.push_back(r);
                    end
                end
                default: begin
                    deg = 0;
                    for (int i = 0; i < n; i++) begin
                        if ($signed(shadow_weight[u][i]) > 0) begin
                            deg++;
                        end
                    end
                    r.edge_total     = shadow_edges;
                    r.neighbor_count = DEG_W'(deg);
                    graph_replies.push_back(r);
                end
            endcase
        end
    endfunction

    // offer one item, idling first at the phase rate; returns on the accepting edge
    task automatic push_item(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] u,
                             input logic [NODE_W-1:0] v, input logic [VAL_W-1:0] w);
        logic [I_DATA_W-1:0] word;
        word = '0;
        word[I_U_LSB +: NODE_W] = u;
        word[I_V_LSB +: NODE_W] = v;
        word[I_W_LSB +: VAL_W]  = w;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        apply_graph_op(op, u, v, w);
    endtask

    // stop sending and wait until every owed result has come back
    task automatic settle_results();
        s_tvalid <= 1'b0;
        while (graph_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write only with the block idle
    task automatic write_node_count(input logic [CFG_W-1:0] count);
        settle_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        shadow_nodes = count;
    endtask

    // mostly in range, now and then any index so range errors keep showing up
    function automatic logic [NODE_W-1:0] pick_node(input int n);
        if (n == 0 || $urandom_range(9) == 0) begin
            return NODE_W'($urandom_range(MAX_NODES - 1));
        end
        return NODE_W'($urandom_range(n - 1));
    endfunction

    // weights biased toward positive so neighbor lists fill, with signs, zero, extremes
    function automatic logic [VAL_W-1:0] pick_weight();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) return VAL_W'($urandom_range(16'h7fff, 1));
        if (pick < 70) return VAL_W'($urandom_range(16'hffff, 16'h8000));
        if (pick < 85) return '0;
        if (pick < 90) return 16'h7fff;
        if (pick < 95) return 16'h8000;
        return VAL_W'($urandom);
    endfunction

    task automatic push_random_item();
        int                pick;
        int                n;
        logic [OP_W-1:0]   op;
        logic [NODE_W-1:0] u;
        logic [NODE_W-1:0] v;
        n    = active_count();
        pick = $urandom_range(99);
        op   = (pick < 35) ? OP_ADD : (pick < 55) ? OP_WQ : (pick < 80) ? OP_NL : OP_DEG;
        u    = pick_node(n);
        v    = pick_node(n);
        // pile edges onto a few hub nodes so their rows hold long neighbor lists
        if (op != OP_WQ && n > 0 && $urandom_range(99) < 40) begin
            u = NODE_W'($urandom_range((n > 4) ? 3 : n - 1));
        end
        push_item(op, u, v, pick_weight());
    endtask

    // result side: random stall, and check of every accepted result item
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_reply();
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic check_reply();
        reply_t want;
        if (graph_replies.size() == 0) begin
            flag_mismatch($sformatf("result item with nothing owed, tdata %h", m_tdata));
        end else begin
            want = graph_replies.pop_front();
            compare_field("node_index", 32'(m_tdata[O_IDX_LSB +: NODE_W]),
                          32'(want.node_index));
            compare_field("edge_value", 32'(m_tdata[O_VAL_LSB +: VAL_W]),
                          32'(want.edge_value));
            compare_field("neighbor_count", 32'(m_tdata[O_DEG_LSB +: DEG_W]),
                          32'(want.neighbor_count));
            compare_field("edge_total", 32'(m_tdata[O_TOT_LSB +: TOTAL_W]),
                          32'(want.edge_total));
            compare_field("is_last", 32'(m_tlast), 32'(want.is_last));
            compare_field("none_found", 32'(m_tuser[U_NONE]), 32'(want.none_found));
            compare_field("index_error", 32'(m_tuser[U_ERR]), 32'(want.index_error));
        end
    endtask

    // stimulus
    initial begin
        reply_t typed_reply;
        int     spin;

        for (int i = 0; i < MAX_NODES; i++) begin
            for (int j = 0; j < MAX_NODES; j++) begin
                shadow_weight[i][j] = '0;
            end
        end
        shadow_edges = '0;
        shadow_nodes = CFG_W'(MAX_NODES);

        // reset held low first; the clearing pass then holds off s_tready by itself
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, no idling
        for (int r = 0; r < PLAN_LEN; r++) begin
            if (PLAN[r].is_cfg == ROW_CFG) begin
                write_node_count(PLAN[r].cfg);
            end else begin
                push_item(PLAN[r].op, PLAN[r].u, PLAN[r].v, PLAN[r].w);
                if (PLAN[r].typed) begin
                    // single-result rows: the hand-written result replaces the shadow one
                    typed_reply                = '0;
                    typed_reply.edge_value     = PLAN[r].want_val;
                    typed_reply.neighbor_count = PLAN[r].want_deg;
                    typed_reply.edge_total     = PLAN[r].want_tot;
                    typed_reply.is_last        = 1'b1;
                    typed_reply.none_found     = PLAN[r].want_none;
                    typed_reply.index_error    = PLAN[r].want_err;
                    void'(graph_replies.pop_back());
                    graph_replies.push_back(typed_reply);
                end
            end
        end

        // random phases, each with its own node count and idling mix
        for (int ph = 0; ph < PHASES; ph++) begin
            write_node_count(PHASE_NODES[ph]);
            send_idle_pct = SEND_IDLE[ph % 4];
            stall_pct     = RECV_IDLE[ph % 4];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // one mid-phase pause until the block has caught up completely
                if (ph == 2 && k == PHASE_ITEMS / 2) begin
                    settle_results();
                end
                push_random_item();
            end
        end

        // a short tail at full size with light idling on both sides
        write_node_count(CFG_W'(MAX_NODES));
        send_idle_pct = 12;
        stall_pct     = 12;
        for (int k = 0; k < TAIL_ITEMS; k++) begin
            push_random_item();
        end

        // drain, then give the block one more scan's worth of cycles
        s_tvalid <= 1'b0;
        for (spin = 0; spin < DRAIN_SPIN && graph_replies.size() != 0; spin++) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (graph_replies.size() != 0) begin
            flag_mismatch($sformatf("%0d result items never arrived", graph_replies.size()));
        end

        if (mismatch_count == 0) begin
            $display("adjacency_matrix_graph_store: match");
        end else begin
            $display("adjacency_matrix_graph_store: mismatch");
        end
        $finish;
    end

endmodule

### files.f
design/amgs_pkg.sv
design/adjacency_matrix_graph_store.sv
design/amgs_checker.sv
tb/tb_adjacency_matrix_graph_store.sv
